// ===== design/fps_pkg.sv =====
// Shared types and constants for the five-point stencil stream.
// No dependencies; imported by the stencil top level.
package fps_pkg;

   localparam int DEF_MAX_COLS    = 4096;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int COLS_CFG_BITS = 13;
   localparam int ROW_BITS      = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_COLS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_ROWS = 2'd1;

   localparam int GRID_COLS_RESET = 4096;
   localparam int GRID_ROWS_RESET = 4096;
   localparam int GRID_MIN        = 3;

   // Per-item flags carried from acceptance to the compute stage.
   typedef struct packed {
      logic emit_above;  // a cell of the previous row is due
      logic interior;    // that cell is updated rather than passed through
      logic final_row;   // the sample itself is also emitted
      logic last_col;    // the sample is the grid's final cell if final_row
   } s1_info_type;

endpackage

// ===== design/fps_line_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; holds the stencil's line stores.
module fps_line_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== design/five_point_stencil_stream.sv =====
// Five-point Jacobi stencil over a raster-order sample stream.
// Depends on fps_pkg and fps_line_ram.
//
// One grid sample is taken per cycle while the result buffer has room. While
// row r arrives, row r-1 leaves one cell per sample, through the compute stage
// and then the result buffer from the sample that completes its neighbourhood;
// row 0 gives no results. In the final row every sample gives two results (the
// cell above, then the sample itself), so there the single result port holds
// the input back until each pair is taken. Both line stores share one MAX_COLS
// deep memory, read at two columns per sample; stale entries need no clearing,
// as none reaches a result. A column or row register write starts a new grid.
module five_point_stencil_stream
   import fps_pkg::*;
#(
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_value,
   output logic                          rsp_last_of_item,
   output logic                          rsp_end_of_grid,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int ColBits = $clog2(MAX_COLS);
   localparam int SumBits = SAMPLE_BITS + 2;

   // Configuration, held as the last column and row index in use.
   logic [ColBits-1:0]  col_last_ff, col_last_in;
   logic [ROW_BITS-1:0] row_last_ff, row_last_in;
   logic [ColBits-1:0]  col_pos_ff, col_pos_in;
   logic [ROW_BITS-1:0] row_pos_ff, row_pos_in;

   logic [31:0] cols_wide;
   logic [31:0] rows_wide;

   // Compute stage.
   logic                          s1_valid_ff, s1_valid_in;
   s1_info_type                   s1_info_ff, s1_info_in;
   logic [ColBits-1:0]            s1_col_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic signed [SAMPLE_BITS-1:0] left_ff;

   // Result buffer of two entries; entry a is shown on the port.
   logic [1:0]                    out_cnt_ff, out_cnt_in;
   logic signed [SAMPLE_BITS-1:0] out_a_value_ff, out_a_value_in;
   logic                          out_a_last_ff, out_a_last_in;
   logic                          out_a_eog_ff, out_a_eog_in;
   logic signed [SAMPLE_BITS-1:0] out_b_value_ff, out_b_value_in;
   logic                          out_b_eog_ff, out_b_eog_in;

   logic req_xfer;
   logic out_free;
   logic s1_adv;

   logic [ColBits-1:0]              rd_addr_b;
   logic [2*SAMPLE_BITS-1:0]        rd_data_a;
   logic [2*SAMPLE_BITS-1:0]        rd_data_b;
   logic signed [SAMPLE_BITS-1:0]   up_val;
   logic signed [SAMPLE_BITS-1:0]   center_val;
   logic signed [SAMPLE_BITS-1:0]   right_val;
   logic signed [SumBits-1:0]       sum;
   logic signed [SumBits-1:0]       quarter;
   logic signed [SAMPLE_BITS-1:0]   above_val;

   assign out_free  = (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_ready);
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_xfer  = req_valid && req_ready;

   // ---------------------------------------------------------------- config
   always_comb begin
      cols_wide   = 32'(csr_wdata[COLS_CFG_BITS-1:0]);
      rows_wide   = 32'(csr_wdata[ROW_BITS-1:0]);
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      if (csr_wr_en && (csr_index == CSR_GRID_COLS)) begin
         if (cols_wide < 32'(GRID_MIN)) begin
            col_last_in = ColBits'(GRID_MIN - 1);
         end else if (cols_wide > 32'(MAX_COLS)) begin
            col_last_in = ColBits'(MAX_COLS - 1);
         end else begin
            col_last_in = ColBits'(cols_wide - 32'd1);
         end
      end
      if (csr_wr_en && (csr_index == CSR_GRID_ROWS)) begin
         if (rows_wide < 32'(GRID_MIN)) begin
            row_last_in = ROW_BITS'(GRID_MIN - 1);
         end else begin
            row_last_in = ROW_BITS'(rows_wide - 32'd1);
         end
      end
   end

   // ------------------------------------------------------------ positions
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      priority if (csr_wr_en && ((csr_index == CSR_GRID_COLS) ||
                                 (csr_index == CSR_GRID_ROWS))) begin
         col_pos_in = '0;
         row_pos_in = '0;
      end else if (req_xfer) begin
         if (col_pos_ff == col_last_ff) begin
            col_pos_in = '0;
            row_pos_in = (row_pos_ff == row_last_ff) ? '0 : row_pos_ff + 1'b1;
         end else begin
            col_pos_in = col_pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_info_in.emit_above = (row_pos_ff != '0);
      s1_info_in.interior   = (row_pos_ff > ROW_BITS'(1)) && (col_pos_ff != '0) &&
                              (col_pos_ff != col_last_ff);
      s1_info_in.final_row  = (row_pos_ff == row_last_ff);
      s1_info_in.last_col   = (col_pos_ff == col_last_ff);
      s1_valid_in           = req_xfer || (s1_valid_ff && !s1_adv);
   end

   // The right neighbour is never used at the last column.
   assign rd_addr_b = (col_pos_ff == col_last_ff) ? col_pos_ff : col_pos_ff + 1'b1;

   // Each entry holds {row two back, row one back} for its column.
   fps_line_ram #(
      .WIDTH (2*SAMPLE_BITS),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (s1_adv),
      .wr_addr   (s1_col_ff),
      .wr_data   ({center_val, s1_sample_ff}),
      .rd_en     (req_xfer),
      .rd_addr_a (col_pos_ff),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // ---------------------------------------------------------------- compute
   always_comb begin
      up_val     = rd_data_a[2*SAMPLE_BITS-1:SAMPLE_BITS];
      center_val = rd_data_a[SAMPLE_BITS-1:0];
      right_val  = rd_data_b[SAMPLE_BITS-1:0];
      // The left neighbour is the centre of the previous column.
      sum        = SumBits'(left_ff) + SumBits'(up_val) + SumBits'(right_val) +
                   SumBits'(s1_sample_ff);
      quarter    = sum >>> 2;
      above_val  = s1_info_ff.interior ? quarter[SAMPLE_BITS-1:0] : center_val;
   end

   // ---------------------------------------------------------- result buffer
   always_comb begin
      out_cnt_in     = out_cnt_ff;
      out_a_value_in = out_a_value_ff;
      out_a_last_in  = out_a_last_ff;
      out_a_eog_in   = out_a_eog_ff;
      out_b_value_in = out_b_value_ff;
      out_b_eog_in   = out_b_eog_ff;
      if (rsp_valid && rsp_ready) begin
         out_cnt_in     = out_cnt_ff - 2'd1;
         out_a_value_in = out_b_value_ff;
         out_a_last_in  = 1'b1;
         out_a_eog_in   = out_b_eog_ff;
      end
      if (s1_adv) begin
         out_a_value_in = above_val;
         out_a_last_in  = !s1_info_ff.final_row;
         out_a_eog_in   = 1'b0;
         out_b_value_in = s1_sample_ff;
         out_b_eog_in   = s1_info_ff.last_col;
         priority if (!s1_info_ff.emit_above) begin
            out_cnt_in = 2'd0;
         end else if (s1_info_ff.final_row) begin
            out_cnt_in = 2'd2;
         end else begin
            out_cnt_in = 2'd1;
         end
      end
   end

   assign rsp_valid        = (out_cnt_ff != 2'd0);
   assign rsp_value        = out_a_value_ff;
   assign rsp_last_of_item = out_a_last_ff;
   assign rsp_end_of_grid  = out_a_eog_ff;

   // -------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= ColBits'((GRID_COLS_RESET > MAX_COLS ? MAX_COLS : GRID_COLS_RESET) - 1);
         row_last_ff <= ROW_BITS'(GRID_ROWS_RESET - 1);
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
         out_cnt_ff  <= 2'd0;
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         s1_valid_ff <= s1_valid_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_info_ff   <= s1_info_in;
         s1_col_ff    <= col_pos_ff;
         s1_sample_ff <= req_sample;
      end
      if (s1_adv) begin
         left_ff <= center_val;
      end
      out_a_value_ff <= out_a_value_in;
      out_a_last_ff  <= out_a_last_in;
      out_a_eog_ff   <= out_a_eog_in;
      out_b_value_ff <= out_b_value_in;
      out_b_eog_ff   <= out_b_eog_in;
   end

`ifndef SYNTHESIS
   a_out_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= 2'd2)
      else $error("result buffer holds more than two entries");

   a_eog_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_grid |-> rsp_last_of_item)
      else $error("end of grid shown on a result that is not the item's last");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (col_pos_ff == col_last_ff) |=> (col_pos_ff == '0))
      else $error("column position did not wrap after the last column");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_pos_ff <= row_last_ff)
      else $error("row position beyond the last row");

   a_final_pair: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_info_ff.final_row |=> (out_cnt_ff == 2'd2))
      else $error("final-row item did not load two results");
`endif

endmodule
